### sv/assert_macros.svh
// Assertion macros shared by the echo block.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

### sv/sec_pkg.sv
// Package for the stereo echo block: widths, limits, register codes and
// the control and status structs between history store and top level.
package sec_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_DELAY   = 131072;
    localparam int ADDR_W      = $clog2(MAX_DELAY);
    localparam int SEEN_W      = $clog2(MAX_DELAY + 1);
    localparam int DELAY_W     = 17;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 15;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = DELAY_W;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic load;
        logic last;
    } hist_ctl_t;

    typedef struct packed {
        logic [ADDR_W-1:0] wr_ptr;
        logic [SEEN_W-1:0] seen;
    } hist_stat_t;

endpackage

### sv/sec_history.sv
// Frame history ring: stores each accepted frame and fetches the delayed
// source frame into a register. Depends on sec_pkg.
module sec_history (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sec_pkg::hist_ctl_t           ctl,
    input  sec_pkg::sample_t             left_in,
    input  sec_pkg::sample_t             right_in,
    input  logic [sec_pkg::DELAY_W-1:0]  delay_frames,
    output sec_pkg::sample_t             src_left,
    output sec_pkg::sample_t             src_right,
    output sec_pkg::hist_stat_t          stat
);
    import sec_pkg::*;

    logic [2*SAMPLE_BITS-1:0] mem [MAX_DELAY];
    logic [ADDR_W-1:0]        wp_reg, wp_next;
    logic [SEEN_W-1:0]        seen_reg, seen_next;
    sample_t                  src_l_reg, src_r_reg;
    logic [SEEN_W:0]          wp_x, d_x, idx_x;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     use_hist;

    always_comb begin
        wp_x  = (SEEN_W+1)'(wp_reg);
        d_x   = (SEEN_W+1)'(delay_frames);
        if (wp_x >= d_x) begin
            idx_x = wp_x - d_x;
        end else begin
            idx_x = wp_x + (SEEN_W+1)'(MAX_DELAY) - d_x;
        end
        rd_addr  = idx_x[ADDR_W-1:0];
        use_hist = ((SEEN_W+1)'(delay_frames) <= (SEEN_W+1)'(MAX_DELAY)) &&
                   ((DELAY_W+SEEN_W)'(delay_frames) <= (DELAY_W+SEEN_W)'(seen_reg));

        if (wp_reg == ADDR_W'(MAX_DELAY - 1)) begin
            wp_next = '0;
        end else begin
            wp_next = wp_reg + 1'b1;
        end
        if (seen_reg < SEEN_W'(MAX_DELAY)) begin
            seen_next = seen_reg + 1'b1;
        end else begin
            seen_next = seen_reg;
        end
        // a last frame starts a new buffer
        if (ctl.last) begin
            wp_next   = '0;
            seen_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            seen_reg <= '0;
        end else if (ctl.load) begin
            wp_reg   <= wp_next;
            seen_reg <= seen_next;
        end
    end

    // read before write: the fetch sees the entry as it stood before this write
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            mem[wp_reg] <= {right_in, left_in};
            if (delay_frames == '0) begin
                src_l_reg <= left_in;
                src_r_reg <= right_in;
            end else if (use_hist) begin
                {src_r_reg, src_l_reg} <= mem[rd_addr];
            end else begin
                src_l_reg <= '0;
                src_r_reg <= '0;
            end
        end
    end

    assign src_left    = src_l_reg;
    assign src_right   = src_r_reg;
    assign stat.wr_ptr = wp_reg;
    assign stat.seen   = seen_reg;

endmodule

### sv/sec_lane.sv
// One channel lane: registered gain product, then truncation toward zero,
// add and saturation. Depends on sec_pkg.
module sec_lane (
    input  logic                        aclk,
    input  logic                        load,
    input  sec_pkg::sample_t            cur,
    input  sec_pkg::sample_t            src,
    input  logic [sec_pkg::GAIN_W-1:0]  gain,
    output sec_pkg::sample_t            mixed
);
    import sec_pkg::*;

    localparam int SCALED_W = PROD_W - GAIN_FRAC;
    localparam int SUM_W    = SCALED_W + 1;

    logic signed [PROD_W-1:0]   prod_reg;
    sample_t                    cur_reg;
    logic signed [PROD_W-1:0]   prod_adj;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sat_hi, sat_lo;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= PROD_W'(src) * $signed({1'b0, gain});
            cur_reg  <= cur;
        end
    end

    always_comb begin
        // bias negatives so the shift rounds toward zero
        if (prod_reg[PROD_W-1]) begin
            prod_adj = prod_reg + PROD_W'((1 << GAIN_FRAC) - 1);
        end else begin
            prod_adj = prod_reg;
        end
        scaled = SCALED_W'(prod_adj >>> GAIN_FRAC);
        sum    = SUM_W'(cur_reg) + SUM_W'(scaled);
        sat_hi = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
        sat_lo = -sat_hi - SUM_W'(1);
        if (sum > sat_hi) begin
            mixed = sample_t'(sat_hi);
        end else if (sum < sat_lo) begin
            mixed = sample_t'(sat_lo);
        end else begin
            mixed = sample_t'(sum);
        end
    end

endmodule

### sv/stereo_echo_saturating.sv
// Stereo echo with saturation: one frame per item.
// Each accepted frame passes the registered stages in order: history fetch,
// product register, output register. Throughput: one frame per cycle while
// m_tready does not stall the output, set by the single write/read port pair of the history ring.
// Reset (aresetn low, synchronous) clears pointers, config registers and valids;
// the history memory is not cleared and is never read before being written.
module stereo_echo_saturating (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // left_in, right_in
    input  logic                            s_tlast,   // last_frame
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // left_out, right_out
    output logic                            m_tlast,   // last_out
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sec_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sec_pkg::*;
    `include "assert_macros.svh"

    logic [DELAY_W-1:0] delay_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               v1_reg, v2_reg, vo_reg;
    logic               last1_reg, last2_reg, lasto_reg;
    sample_t            cur_l_reg, cur_r_reg;
    sample_t            out_l_reg, out_r_reg;
    sample_t            src_l, src_r, mix_l, mix_r;
    logic               en_out, en2, en1, in_acc;
    hist_ctl_t          hctl;
    hist_stat_t         hstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
            gain_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DELAY: delay_reg <= cfg_data[DELAY_W-1:0];
                REG_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                default:   ;
            endcase
        end
    end

    // each stage advances when the one after it is empty or moving
    assign en_out   = !vo_reg || m_tready;
    assign en2      = !v2_reg || en_out;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign in_acc   = s_tvalid && en1;

    assign hctl.load = in_acc;
    assign hctl.last = s_tlast;

    sec_history u_history (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (hctl),
        .left_in      (s_tdata[SAMPLE_BITS-1:0]),
        .right_in     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .delay_frames (delay_reg),
        .src_left     (src_l),
        .src_right    (src_r),
        .stat         (hstat)
    );

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cur_l_reg <= s_tdata[SAMPLE_BITS-1:0];
            cur_r_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            last1_reg <= s_tlast;
        end
    end

    sec_lane u_lane_left (
        .aclk  (aclk),
        .load  (v1_reg && en2),
        .cur   (cur_l_reg),
        .src   (src_l),
        .gain  (gain_reg),
        .mixed (mix_l)
    );

    sec_lane u_lane_right (
        .aclk  (aclk),
        .load  (v1_reg && en2),
        .cur   (cur_r_reg),
        .src   (src_r),
        .gain  (gain_reg),
        .mixed (mix_r)
    );

    always_ff @(posedge aclk) begin
        if (v1_reg && en2) begin
            last2_reg <= last1_reg;
        end
        // merge both lanes into the output item
        if (v2_reg && en_out) begin
            out_l_reg <= mix_l;
            out_r_reg <= mix_r;
            lasto_reg <= last2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en_out) begin
                vo_reg <= v2_reg;
            end
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {out_r_reg, out_l_reg};
    assign m_tlast  = lasto_reg;

    `ASSERT_IMPLIES(a_full_when_blocked, aclk, aresetn, !s_tready, v1_reg && v2_reg && vo_reg)
    `ASSERT_NEXT(a_last_restarts, aclk, aresetn, in_acc && s_tlast, hstat.wr_ptr == '0 && hstat.seen == '0)
    `ASSERT_IMPLIES(a_seen_bounded, aclk, aresetn, 1'b1, hstat.seen <= SEEN_W'(MAX_DELAY))

endmodule

### dv/stereo_echo_saturating_tb.sv
`timescale 1ns / 1ps
// Testbench for stereo_echo_saturating: directed and random stereo frames with
// a built-in echo predictor and a scoreboard on the result stream.
// Depends on sec_pkg and the stereo_echo_saturating RTL.
module stereo_echo_saturating_tb;
    import sec_pkg::*;

    typedef struct {
        sample_t left;
        sample_t right;
        logic    tail;
    } echo_frame_t;

    localparam int MAX_PRINTS = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;    // left_in, right_in
    logic                  s_tlast = 1'b0;  // last_frame
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;         // left_out, right_out
    logic                  m_tlast;         // last_out
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: register copies and the frame ring.
    logic [DELAY_W-1:0] delay_cfg = '0;
    logic [GAIN_W-1:0]  gain_cfg = '0;
    sample_t            ring_left [0:MAX_DELAY-1];
    sample_t            ring_right [0:MAX_DELAY-1];
    logic [ADDR_W-1:0]  ring_ptr = '0;
    logic [SEEN_W-1:0]  ring_fill = '0;

    echo_frame_t        pending_frames[$];
    int                 mismatch_count = 0;
    bit                 gaps_on = 1'b0;
    bit                 stall_on = 1'b0;

    stereo_echo_saturating dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Add the scaled echo (truncated toward zero) and clamp to the sample range.
    function automatic sample_t echo_mix(sample_t cur, sample_t src);
        longint scaled;
        longint sum;
        scaled = (longint'(src) * longint'(gain_cfg)) / 32768;
        sum = longint'(cur) + scaled;
        if (sum > 32767) return sample_t'(32767);
        if (sum < -32768) return sample_t'(-32768);
        return sample_t'(sum);
    endfunction

    function automatic void predict_echo(sample_t l, sample_t r, logic tail);
        sample_t           src_l;
        sample_t           src_r;
        logic [ADDR_W-1:0] rd;
        echo_frame_t       f;
        src_l = '0;
        src_r = '0;
        // Delay is at most MAX_DELAY-1 at this width, so it always fits the ring.
        if (delay_cfg == 0) begin
            src_l = l;
            src_r = r;
        end else if (ring_fill >= delay_cfg) begin
            rd = ring_ptr - ADDR_W'(delay_cfg);
            src_l = ring_left[rd];
            src_r = ring_right[rd];
        end
        f.left = echo_mix(l, src_l);
        f.right = echo_mix(r, src_r);
        f.tail = tail;
        pending_frames.push_back(f);
        ring_left[ring_ptr] = l;
        ring_right[ring_ptr] = r;
        ring_ptr = ring_ptr + 1'b1;
        if (ring_fill < MAX_DELAY) ring_fill = ring_fill + 1'b1;
        if (tail) begin
            ring_ptr = '0;
            ring_fill = '0;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t ns: MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        echo_frame_t f;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("unexpected result item", int'(m_tdata), 0);
            end else begin
                f = pending_frames.pop_front();
                if ($signed(m_tdata[15:0]) !== f.left)
                    report_mismatch("left_out", $signed(m_tdata[15:0]), f.left);
                if ($signed(m_tdata[31:16]) !== f.right)
                    report_mismatch("right_out", $signed(m_tdata[31:16]), f.right);
                if (m_tlast !== f.tail)
                    report_mismatch("last_out", m_tlast, f.tail);
            end
        end
    end

    // Result side back-pressure in random bursts.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_frame(sample_t l, sample_t r, logic tail);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        s_tlast <= tail;
        do @(posedge aclk); while (!s_tready);
        predict_echo(l, r, tail);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DELAY: delay_cfg = val[DELAY_W-1:0];
            REG_GAIN:  gain_cfg = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_echo(int unsigned delay, int unsigned gain);
        write_reg(REG_DELAY, CFG_DATA_W'(delay));
        write_reg(REG_GAIN, CFG_DATA_W'(gain));
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every result, then let the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (pending_frames.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 5))
            0: return sample_t'(32767 - $urandom_range(0, 3));
            1: return sample_t'(-32768 + $urandom_range(0, 3));
            2: return sample_t'($urandom_range(0, 64) - 32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        // Reset gain is zero: output equals input.
        send_frame(16'sh7fff, -16'sh8000, 1'b0);
        send_frame(16'sh5555, 16'shaaaa, 1'b0);
        wait_idle();
    endtask

    task automatic test_zero_delay();
        gaps_on = 1'b1;
        stall_on = 1'b1;
        // Zero delay mixes the frame with itself.
        set_echo(0, 32768);
        send_frame(16'sh7fff, -16'sh8000, 1'b0);
        send_frame(16'sh4000, -16'sh4001, 1'b0);
        send_frame(-16'sh0001, 16'sh0001, 1'b0);
        send_frame(16'sh0000, 16'sh0000, 1'b0);
        wait_idle();
        // Gain just under two: saturates both ways.
        set_echo(0, 65535);
        send_frame(16'sh7fff, -16'sh8000, 1'b0);
        send_frame(16'sh3039, -16'sh3039, 1'b0);
        send_frame(16'sh0001, -16'sh0001, 1'b0);
        send_frame(-16'sh0001, 16'sh2aaa, 1'b1);
        wait_idle();
    endtask

    task automatic test_buffer_start();
        // Frames before the buffer start count as zero; a last frame restarts it.
        set_echo(3, 32768);
        for (int i = 0; i < 10; i++)
            send_frame(pick_sample(), pick_sample(), i == 4 || i == 9);
        wait_idle();
    endtask

    task automatic test_truncation();
        // Tiny gain: scaled copy truncates toward zero for both signs.
        set_echo(1, 1);
        send_frame(-16'sh8000, 16'sh7fff, 1'b0);
        send_frame(-16'sh0001, 16'sh0001, 1'b0);
        send_frame(16'sh0005, -16'sh0005, 1'b0);
        wait_idle();
        set_echo(1, 16384);
        send_frame(-16'sh0001, 16'sh0003, 1'b0);
        send_frame(16'sh0000, 16'sh0000, 1'b1);
        wait_idle();
    endtask

    task automatic test_max_delay();
        // Longest delay: a short buffer never reaches the source frame, so no echo.
        gaps_on = 1'b0;
        stall_on = 1'b0;
        set_echo(MAX_DELAY - 1, 65535);
        for (int i = 0; i < 40; i++)
            send_frame(pick_sample(), pick_sample(), i == 39);
        wait_idle();
    endtask

    task automatic test_random();
        int unsigned delay;
        int unsigned gain;
        int          left_in_phase;
        int          run_len;
        for (int phase = 0; phase < 10; phase++) begin
            // No idling in the last phases.
            gaps_on = (phase < 8) && ($urandom_range(0, 3) != 0);
            stall_on = (phase < 8) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0: delay = 0;
                1: delay = $urandom_range(1000, MAX_DELAY - 1);
                2: delay = $urandom_range(25, 200);
                default: delay = $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 5))
                0: gain = 0;
                1: gain = 32768;
                2: gain = 65535;
                default: gain = $urandom_range(0, 65535);
            endcase
            if (phase == 0) gain = 0;
            set_echo(delay, gain);
            left_in_phase = 130;
            while (left_in_phase > 0) begin
                run_len = $urandom_range(1, 48);
                if (run_len > left_in_phase) run_len = left_in_phase;
                for (int i = 0; i < run_len; i++) begin
                    // Mostly well-formed buffers; a few stray last marks.
                    send_frame(pick_sample(), pick_sample(),
                               (i == run_len - 1) || ($urandom_range(0, 19) == 0));
                end
                left_in_phase -= run_len;
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_zero_delay();
        test_buffer_start();
        test_truncation();
        test_max_delay();
        test_random();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
